FILE: rtl/sic_pkg.sv
// Shared types and constants of the segment intersection classifier.
package sic_pkg;

	localparam int CW  = 32;
	localparam int DW  = 33;
	localparam int PW  = 66;
	localparam int SW  = 68;
	localparam int PTW = 16;
	localparam int TLW = 40;
	localparam int KW  = 2;
	localparam int IXW = 1;

	localparam logic [KW-1:0] KIND_COIN = 2'd0;
	localparam logic [KW-1:0] KIND_HIT  = 2'd1;
	localparam logic [KW-1:0] KIND_MISS = 2'd2;

	localparam logic [IXW-1:0] CFG_POINT_TOL = 1'd0;
	localparam logic [IXW-1:0] CFG_PROD_TOL  = 1'd1;

	localparam logic [PTW-1:0] POINT_TOL_RST = 16'd7;
	localparam logic [TLW-1:0] PROD_TOL_RST  = 40'd429497;

	typedef struct packed {
		logic signed [CW-1:0] a1_x;
		logic signed [CW-1:0] a1_y;
		logic signed [CW-1:0] a2_x;
		logic signed [CW-1:0] a2_y;
		logic signed [CW-1:0] b1_x;
		logic signed [CW-1:0] b1_y;
		logic signed [CW-1:0] b2_x;
		logic signed [CW-1:0] b2_y;
	} seg_pair_t;

	typedef struct packed {
		logic [KW-1:0]        kind;
		logic signed [CW-1:0] cross_x;
		logic signed [CW-1:0] cross_y;
	} seg_result_t;

	typedef struct packed {
		logic [KW-1:0]        kind;
		logic [SW-1:0]        den;
		logic [SW-1:0]        tn;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} work_t;

endpackage

FILE: rtl/sic_front.sv
// Front pipeline: differences, cross products, determinant test and classification.
module sic_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [sic_pkg::PTW-1:0]  point_tol,
	input  logic [sic_pkg::TLW-1:0]  prod_tol,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  sic_pkg::seg_pair_t       in_data,
	output logic                     work_valid,
	input  logic                     work_ready,
	output sic_pkg::work_t           work
);

	typedef struct packed {
		logic va;
		logic vb;
		logic sx13;
		logic sp;
	} flag_t;

	function automatic logic signed [sic_pkg::DW-1:0] dif(
		input logic signed [sic_pkg::CW-1:0] p,
		input logic signed [sic_pkg::CW-1:0] q
	);
		dif = $signed({p[sic_pkg::CW-1], p}) - $signed({q[sic_pkg::CW-1], q});
	endfunction

	function automatic logic same(
		input logic signed [sic_pkg::DW-1:0] d,
		input logic [sic_pkg::PTW-1:0]       t
	);
		logic [sic_pkg::DW-1:0] m;
		m = d[sic_pkg::DW-1] ? sic_pkg::DW'(-d) : sic_pkg::DW'(d);
		same = m < {{(sic_pkg::DW-sic_pkg::PTW){1'b0}}, t};
	endfunction

	function automatic logic signed [sic_pkg::SW-1:0] sx(
		input logic signed [sic_pkg::PW-1:0] p
	);
		sx = $signed({{(sic_pkg::SW-sic_pkg::PW){p[sic_pkg::PW-1]}}, p});
	endfunction

	function automatic logic [sic_pkg::SW-1:0] mag(input logic signed [sic_pkg::SW-1:0] v);
		mag = v[sic_pkg::SW-1] ? sic_pkg::SW'(-v) : sic_pkg::SW'(v);
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [sic_pkg::DW-1:0] d12x_s1, d12y_s1, d34x_s1, d34y_s1;
	logic signed [sic_pkg::DW-1:0] d13x_s1, d13y_s1, d21x_s1, d21y_s1, d32x_s1, d32y_s1;
	logic signed [sic_pkg::CW-1:0] ax_s1, ay_s1;
	flag_t                         fl_s1;

	logic signed [sic_pkg::PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2, pg_s2, ph_s2;
	logic signed [sic_pkg::DW-1:0] dx_s2, dy_s2;
	logic signed [sic_pkg::CW-1:0] ax_s2, ay_s2;
	flag_t                         fl_s2;

	logic signed [sic_pkg::SW-1:0] den_s3, tn_s3, un_s3, col_s3;
	logic signed [sic_pkg::DW-1:0] dx_s3, dy_s3;
	logic signed [sic_pkg::CW-1:0] ax_s3, ay_s3;
	flag_t                         fl_s3;

	logic [sic_pkg::SW-1:0]        den_s4, acol_s4;
	logic signed [sic_pkg::SW-1:0] tn_s4, un_s4;
	logic                          dz_s4;
	logic signed [sic_pkg::DW-1:0] dx_s4, dy_s4;
	logic signed [sic_pkg::CW-1:0] ax_s4, ay_s4;
	flag_t                         fl_s4;

	sic_pkg::work_t                work_s5;

	logic [sic_pkg::SW-1:0] tol;
	logic                   low_det, slope, colin, hit;
	logic [sic_pkg::KW-1:0] par_kind;

	assign adv        = !v_s5 || work_ready;
	assign in_ready   = adv;
	assign work_valid = v_s5;
	assign work       = work_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d12x_s1 <= dif(in_data.a1_x, in_data.a2_x);
			d12y_s1 <= dif(in_data.a1_y, in_data.a2_y);
			d34x_s1 <= dif(in_data.b1_x, in_data.b2_x);
			d34y_s1 <= dif(in_data.b1_y, in_data.b2_y);
			d13x_s1 <= dif(in_data.a1_x, in_data.b1_x);
			d13y_s1 <= dif(in_data.a1_y, in_data.b1_y);
			d21x_s1 <= dif(in_data.a2_x, in_data.a1_x);
			d21y_s1 <= dif(in_data.a2_y, in_data.a1_y);
			d32x_s1 <= dif(in_data.b1_x, in_data.a2_x);
			d32y_s1 <= dif(in_data.b1_y, in_data.a2_y);
			ax_s1   <= in_data.a1_x;
			ay_s1   <= in_data.a1_y;
			fl_s1.va   <= in_data.a1_x == in_data.a2_x;
			fl_s1.vb   <= in_data.b1_x == in_data.b2_x;
			fl_s1.sx13 <= same(dif(in_data.a1_x, in_data.b1_x), point_tol);
			fl_s1.sp   <= (same(dif(in_data.a1_x, in_data.a2_x), point_tol) &&
					same(dif(in_data.a1_y, in_data.a2_y), point_tol)) ||
				(same(dif(in_data.a2_x, in_data.b1_x), point_tol) &&
					same(dif(in_data.a2_y, in_data.b1_y), point_tol)) ||
				(same(dif(in_data.a1_x, in_data.b1_x), point_tol) &&
					same(dif(in_data.a1_y, in_data.b1_y), point_tol));

			pa_s2 <= d12x_s1 * d34y_s1;
			pb_s2 <= d12y_s1 * d34x_s1;
			pc_s2 <= d13x_s1 * d34y_s1;
			pd_s2 <= d13y_s1 * d34x_s1;
			pe_s2 <= d21x_s1 * d13y_s1;
			pf_s2 <= d21y_s1 * d13x_s1;
			pg_s2 <= d21x_s1 * d32y_s1;
			ph_s2 <= d21y_s1 * d32x_s1;
			dx_s2 <= d21x_s1;
			dy_s2 <= d21y_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			fl_s2 <= fl_s1;

			den_s3 <= sx(pa_s2) - sx(pb_s2);
			tn_s3  <= sx(pc_s2) - sx(pd_s2);
			un_s3  <= sx(pe_s2) - sx(pf_s2);
			col_s3 <= sx(pg_s2) - sx(ph_s2);
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			fl_s3  <= fl_s2;

			den_s4  <= mag(den_s3);
			tn_s4   <= den_s3[sic_pkg::SW-1] ? -tn_s3 : tn_s3;
			un_s4   <= den_s3[sic_pkg::SW-1] ? -un_s3 : un_s3;
			acol_s4 <= mag(col_s3);
			dz_s4   <= den_s3 == '0;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			fl_s4   <= fl_s3;

			work_s5.kind <= hit ? sic_pkg::KIND_HIT : par_kind;
			work_s5.den  <= den_s4;
			work_s5.tn   <= tn_s4;
			work_s5.ax   <= ax_s4;
			work_s5.ay   <= ay_s4;
			work_s5.dx   <= dx_s4;
			work_s5.dy   <= dy_s4;
		end
	end

	always_comb begin
		tol     = {{(sic_pkg::SW-sic_pkg::TLW){1'b0}}, prod_tol};
		slope   = den_s4 < tol;
		low_det = dz_s4 || slope;
		colin   = fl_s4.sp || (acol_s4 < tol);
		hit     = !low_det &&
			!tn_s4[sic_pkg::SW-1] && (sic_pkg::SW'(tn_s4) <= den_s4) &&
			!un_s4[sic_pkg::SW-1] && (sic_pkg::SW'(un_s4) <= den_s4);
		if (fl_s4.va) begin
			par_kind = (fl_s4.vb && fl_s4.sx13) ? sic_pkg::KIND_COIN : sic_pkg::KIND_MISS;
		end else if (fl_s4.vb) begin
			par_kind = sic_pkg::KIND_MISS;
		end else begin
			par_kind = (slope && colin) ? sic_pkg::KIND_COIN : sic_pkg::KIND_MISS;
		end
	end

endmodule

FILE: rtl/sic_queue.sv
// Short queue between the classifying front and the dividing back.
module sic_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sic_pkg::work_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sic_pkg::work_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	sic_pkg::work_t mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [NW-1:0]  cnt_q;
	logic           push, pop;

	assign push_ready = cnt_q != NW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DEPTH))
		else $error("queue count above depth");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");
	a_ptr_eq: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wp_q == rp_q)
		else $error("queue pointers apart while empty");
`endif

endmodule

FILE: rtl/sic_back.sv
// Back end: bit-serial interpolation divide and result register.
module sic_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                work_valid,
	output logic                work_ready,
	input  sic_pkg::work_t      work,
	output logic                out_valid,
	input  logic                out_ready,
	output sic_pkg::seg_result_t out_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;
	localparam int   NB      = sic_pkg::DW;
	localparam int   CNW     = $clog2(NB + 1);
	localparam int   RW      = sic_pkg::SW + 2;

	function automatic logic [sic_pkg::SW+1:0] step(
		input logic [sic_pkg::SW-1:0] r,
		input logic                   b,
		input logic [sic_pkg::SW-1:0] tn,
		input logic [sic_pkg::SW-1:0] den
	);
		logic [RW-1:0] s, d1, d2;
		s  = {1'b0, r, 1'b0} + (b ? {2'b00, tn} : '0);
		d1 = {2'b00, den};
		d2 = {1'b0, den, 1'b0};
		if (s >= d2) begin
			step = {2'd2, sic_pkg::SW'(s - d2)};
		end else if (s >= d1) begin
			step = {2'd1, sic_pkg::SW'(s - d1)};
		end else begin
			step = {2'd0, sic_pkg::SW'(s)};
		end
	endfunction

	function automatic logic signed [sic_pkg::CW-1:0] fin(
		input logic signed [sic_pkg::CW-1:0] p,
		input logic                          neg,
		input logic [NB-1:0]                 q
	);
		logic [NB:0] qe, sum;
		qe  = neg ? -{1'b0, q} : {1'b0, q};
		sum = {{2{p[sic_pkg::CW-1]}}, p} + qe;
		fin = $signed(sum[sic_pkg::CW-1:0]);
	endfunction

	logic                          st_q;
	logic [CNW-1:0]                cnt_q;
	logic                          ovalid_q;
	sic_pkg::seg_result_t          out_q;
	logic [sic_pkg::SW-1:0]        den_q, tn_q, rx_q, ry_q;
	logic [NB-1:0]                 mx_q, my_q, qx_q, qy_q;
	logic                          nx_q, ny_q;
	logic signed [sic_pkg::CW-1:0] ax_q, ay_q;
	logic                          out_free, take, done;
	logic [sic_pkg::SW+1:0]        stx, sty;

	assign out_free   = !ovalid_q || out_ready;
	assign work_ready = (st_q == ST_IDLE) && out_free;
	assign take       = work_valid && work_ready;
	assign done       = (st_q == ST_DIV) && (cnt_q == '0) && out_free;
	assign out_valid  = ovalid_q;
	assign out_data   = out_q;
	assign stx        = step(rx_q, mx_q[NB-1], tn_q, den_q);
	assign sty        = step(ry_q, my_q[NB-1], tn_q, den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if ((take && (work.kind != sic_pkg::KIND_HIT)) || done) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take && (work.kind == sic_pkg::KIND_HIT)) begin
						st_q  <= ST_DIV;
						cnt_q <= CNW'(NB);
					end
				end
				ST_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (done) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			den_q <= work.den;
			tn_q  <= work.tn;
			ax_q  <= work.ax;
			ay_q  <= work.ay;
			nx_q  <= work.dx[NB-1];
			ny_q  <= work.dy[NB-1];
			mx_q  <= work.dx[NB-1] ? NB'(-work.dx) : NB'(work.dx);
			my_q  <= work.dy[NB-1] ? NB'(-work.dy) : NB'(work.dy);
			rx_q  <= '0;
			ry_q  <= '0;
			qx_q  <= '0;
			qy_q  <= '0;
			if (work.kind != sic_pkg::KIND_HIT) begin
				out_q.kind    <= work.kind;
				out_q.cross_x <= '0;
				out_q.cross_y <= '0;
			end
		end else if ((st_q == ST_DIV) && (cnt_q != '0)) begin
			rx_q <= stx[sic_pkg::SW-1:0];
			ry_q <= sty[sic_pkg::SW-1:0];
			qx_q <= {qx_q[NB-2:0], 1'b0} + NB'(stx[sic_pkg::SW+1:sic_pkg::SW]);
			qy_q <= {qy_q[NB-2:0], 1'b0} + NB'(sty[sic_pkg::SW+1:sic_pkg::SW]);
			mx_q <= {mx_q[NB-2:0], 1'b0};
			my_q <= {my_q[NB-2:0], 1'b0};
		end else if (done) begin
			out_q.kind    <= sic_pkg::KIND_HIT;
			out_q.cross_x <= fin(ax_q, nx_q, qx_q);
			out_q.cross_y <= fin(ay_q, ny_q, qy_q);
		end
	end

`ifndef SYNTHESIS
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> (out_q.kind == sic_pkg::KIND_COIN || out_q.kind == sic_pkg::KIND_HIT ||
			out_q.kind == sic_pkg::KIND_MISS))
		else $error("result kind out of range");
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && out_q.kind != sic_pkg::KIND_HIT |-> out_q.cross_x == '0 &&
			out_q.cross_y == '0)
		else $error("point set on a non-crossing result");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV && cnt_q != '0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("divide step count skipped");
`endif

endmodule

FILE: rtl/segment_intersection_classifier.sv
// Top level: tolerance registers, front classifier, work queue and divide back end.
//  channel   signals                         direction
//  in        in_valid in_ready in_data       segment pair transaction in
//  out       out_valid out_ready out_data    classification transaction out
//  cfg       cfg_valid cfg_ready cfg_index cfg_data   tolerance write in
// Front accepts one transaction per cycle unless its last stage holds a result the queue cannot take.
// Coincident and miss results leave the back end in the cycle after dequeue.
// Crossing results take the shared divide loop: 33 steps plus one final step that writes the result.
// Reset clears all valid and control state; tolerances return to 7 and 429497.
// The front stalls only when the queue is full; the back stalls on out_ready.
module segment_intersection_classifier #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  sic_pkg::seg_pair_t       in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output sic_pkg::seg_result_t     out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [sic_pkg::IXW-1:0]  cfg_index,
	input  logic [sic_pkg::TLW-1:0]  cfg_data
);

	logic [sic_pkg::PTW-1:0] point_tol_q;
	logic [sic_pkg::TLW-1:0] prod_tol_q;
	logic                    fw_valid, fw_ready, bw_valid, bw_ready;
	sic_pkg::work_t          fw, bw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_tol_q <= sic_pkg::POINT_TOL_RST;
			prod_tol_q  <= sic_pkg::PROD_TOL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sic_pkg::CFG_POINT_TOL: point_tol_q <= cfg_data[sic_pkg::PTW-1:0];
				sic_pkg::CFG_PROD_TOL:  prod_tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	sic_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_tol  (point_tol_q),
		.prod_tol   (prod_tol_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.work_valid (fw_valid),
		.work_ready (fw_ready),
		.work       (fw)
	);

	sic_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fw_valid),
		.push_ready (fw_ready),
		.push_data  (fw),
		.pop_valid  (bw_valid),
		.pop_ready  (bw_ready),
		.pop_data   (bw)
	);

	sic_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (bw_valid),
		.work_ready (bw_ready),
		.work       (bw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the segment intersection classifier.
module tb_top;

	class seg_scoreboard;
		sic_pkg::seg_result_t pending[$];
		int errors;

		function void note_pair(sic_pkg::seg_result_t r);
			pending.push_back(r);
		endfunction

		function void check_result(sic_pkg::seg_result_t got);
			sic_pkg::seg_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result kind=%0d x=%h y=%h", got.kind, got.cross_x,
						got.cross_y);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.cross_x !== want.cross_x
					|| got.cross_y !== want.cross_y) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected kind=%0d x=%h y=%h, got kind=%0d x=%h y=%h",
						want.kind, want.cross_x, want.cross_y, got.kind, got.cross_x,
						got.cross_y);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	sic_pkg::seg_pair_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	sic_pkg::seg_result_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [sic_pkg::IXW-1:0] cfg_index = '0;
	logic [sic_pkg::TLW-1:0] cfg_data = '0;

	logic [sic_pkg::PTW-1:0] pt_tol = sic_pkg::POINT_TOL_RST;
	logic [sic_pkg::TLW-1:0] pr_tol = sic_pkg::PROD_TOL_RST;
	seg_scoreboard sb = new();
	int unsigned cycles = 0;
	bit hold_off = 0;
	bit stim_done = 0;

	segment_intersection_classifier DUT (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic logic [127:0] mag(logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [127:0] xprod(logic signed [127:0] ax,
			logic signed [127:0] ay, logic signed [127:0] bx, logic signed [127:0] by);
		return ax * by - ay * bx;
	endfunction

	function automatic bit near(logic signed [127:0] p, logic signed [127:0] q);
		return mag(p - q) < pt_tol;
	endfunction

	function automatic bit small_prod(logic signed [127:0] v);
		return mag(v) < pr_tol;
	endfunction

	function automatic logic [sic_pkg::KW-1:0] parallel_class(logic signed [127:0] x1,
			logic signed [127:0] y1, logic signed [127:0] x2, logic signed [127:0] y2,
			logic signed [127:0] x3, logic signed [127:0] y3, logic signed [127:0] x4,
			logic signed [127:0] y4);
		bit col;
		if (x1 == x2)
			return (x3 == x4 && near(x1, x3)) ? sic_pkg::KIND_COIN : sic_pkg::KIND_MISS;
		if (x3 == x4) return sic_pkg::KIND_MISS;
		if (!small_prod(xprod(x2 - x1, y2 - y1, x4 - x3, y4 - y3))) return sic_pkg::KIND_MISS;
		col = (near(x1, x2) && near(y1, y2)) || (near(x2, x3) && near(y2, y3))
			|| (near(x1, x3) && near(y1, y3))
			|| small_prod(xprod(x2 - x1, y2 - y1, x3 - x2, y3 - y2));
		return col ? sic_pkg::KIND_COIN : sic_pkg::KIND_MISS;
	endfunction

	function automatic logic signed [sic_pkg::CW-1:0] interp(logic signed [127:0] p0,
			logic signed [127:0] d, logic [127:0] t, logic [127:0] den);
		logic [127:0] q;
		logic signed [127:0] r;
		q = (t * mag(d)) / den;
		r = d < 0 ? p0 - $signed(q) : p0 + $signed(q);
		return r[sic_pkg::CW-1:0];
	endfunction

	function automatic sic_pkg::seg_result_t classify(sic_pkg::seg_pair_t s);
		sic_pkg::seg_result_t r;
		logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4, den, tn, un;
		x1 = s.a1_x; y1 = s.a1_y; x2 = s.a2_x; y2 = s.a2_y;
		x3 = s.b1_x; y3 = s.b1_y; x4 = s.b2_x; y4 = s.b2_y;
		r = '0;
		den = xprod(x1 - x2, y1 - y2, x3 - x4, y3 - y4);
		if (den == 0 || small_prod(den)) begin
			r.kind = parallel_class(x1, y1, x2, y2, x3, y3, x4, y4);
			return r;
		end
		tn = xprod(x1 - x3, y1 - y3, x3 - x4, y3 - y4);
		un = xprod(x2 - x1, y2 - y1, x1 - x3, y1 - y3);
		if (den < 0) begin
			den = -den; tn = -tn; un = -un;
		end
		if (tn < 0 || tn > den || un < 0 || un > den) begin
			r.kind = parallel_class(x1, y1, x2, y2, x3, y3, x4, y4);
			return r;
		end
		r.kind = sic_pkg::KIND_HIT;
		r.cross_x = interp(x1, x2 - x1, tn, den);
		r.cross_y = interp(y1, y2 - y1, tn, den);
		return r;
	endfunction

	task automatic idle_gap(int unsigned pct);
		int unsigned n;
		if ($urandom_range(99) >= pct) return;
		in_valid <= 0;
		n = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_pair(sic_pkg::seg_pair_t s, int unsigned pct);
		idle_gap(pct);
		in_valid <= 1;
		in_data <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_pair(classify(s));
	endtask

	task automatic write_reg(logic [sic_pkg::IXW-1:0] idx, logic [sic_pkg::TLW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == sic_pkg::CFG_POINT_TOL) pt_tol = val[sic_pkg::PTW-1:0];
		else pr_tol = val;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [sic_pkg::CW-1:0] rnd_coord(int unsigned mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(2000)) - 1000;
			2: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
			default: return ($signed($urandom_range(200)) - 100) << 16;
		endcase
	endfunction

	function automatic sic_pkg::seg_pair_t rnd_pair();
		sic_pkg::seg_pair_t s;
		int unsigned mode, shape;
		logic signed [sic_pkg::CW-1:0] dx, dy;
		int k;
		mode = $urandom_range(3);
		s = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
		shape = $urandom_range(9);
		if (shape == 0) begin
			s.a2_x = s.a1_x;
			s.b2_x = s.b1_x;
			if ($urandom_range(1)) s.b1_x = s.a1_x + $signed($urandom_range(16)) - 8;
			s.b2_x = s.b1_x;
		end else if (shape == 1) begin
			dx = ($signed($urandom_range(40)) - 20) <<< 16;
			dy = ($signed($urandom_range(40)) - 20) <<< 16;
			k = $signed($urandom_range(6)) - 3;
			s.a1_x = rnd_coord(3); s.a1_y = rnd_coord(3);
			s.a2_x = s.a1_x + dx; s.a2_y = s.a1_y + dy;
			s.b1_x = s.a1_x + k * dx + $signed($urandom_range(4)) - 2;
			s.b1_y = s.a1_y + k * dy;
			s.b2_x = s.b1_x + dx * ($urandom_range(1) ? 1 : -1);
			s.b2_y = s.b1_y + dy * ($urandom_range(1) ? 1 : -1);
		end else if (shape == 2) begin
			s.b1_x = s.a1_x + $signed($urandom_range(10)) - 5;
			s.b1_y = s.a1_y + $signed($urandom_range(10)) - 5;
		end
		return s;
	endfunction

	task automatic run_random(int n);
		repeat (n) send_pair(rnd_pair(), 30);
	endtask

	task automatic run_directed();
		sic_pkg::seg_pair_t s;
		// plain X crossing with a negative determinant
		send_pair({-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536,
			-32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536}, 0);
		// X crossing with a positive determinant
		send_pair({-32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536,
			-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536}, 0);
		// interior crossing at a fractional point, truncation check
		send_pair({32'sd0, 32'sd0, 32'sd3, 32'sd7, 32'sd0, 32'sd5, 32'sd3, -32'sd2}, 0);
		// extreme coordinates
		send_pair({32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000}, 0);
		send_pair({32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000}, 0);
		send_pair({8{32'h80000000}}, 0);
		send_pair({8{32'h7fffffff}}, 0);
		send_pair({8{32'hffffffff}}, 0);
		// both vertical, x three apart and x far apart
		send_pair({32'sd5, 32'sd0, 32'sd5, 32'sd99, 32'sd8, 32'sd3, 32'sd8, 32'sd70}, 0);
		send_pair({32'sd5, 32'sd0, 32'sd5, 32'sd99, 32'sd50, 32'sd3, 32'sd50, 32'sd70}, 0);
		// only a vertical, only b vertical
		send_pair({32'sd5, 32'sd0, 32'sd5, 32'sd9, 32'sd9, 32'sd3, 32'sd11, 32'sd700000}, 0);
		send_pair({32'sd0, 32'sd0, 32'sd9, 32'sd9, 32'sd100, 32'sd0, 32'sd100, 32'sd9}, 0);
		// collinear overlap, parallel apart
		send_pair({32'sd0, 32'sd0, 32'sd655360, 32'sd655360,
			32'sd131072, 32'sd131072, 32'sd1310720, 32'sd1310720}, 0);
		send_pair({32'sd0, 32'sd0, 32'sd655360, 32'sd0,
			32'sd0, 32'sd655360, 32'sd655360, 32'sd655360}, 0);
		// shared point, disjoint
		send_pair({32'sd0, 32'sd0, 32'sd65536, 32'sd3, 32'sd2, 32'sd1, 32'sd1, 32'sd1}, 0);
		send_pair({32'sd0, 32'sd0, 32'sd65536, 32'sd0,
			32'sd131072, 32'sd65536, 32'sd196608, -32'sd65536}, 0);
		s = '0;
		send_pair(s, 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_directed();
		run_random(400);
		drain();
		write_reg(sic_pkg::CFG_POINT_TOL, '0);
		write_reg(sic_pkg::CFG_PROD_TOL, '0);
		run_directed();
		run_random(400);
		drain();
		write_reg(sic_pkg::CFG_POINT_TOL, 40'hffff);
		write_reg(sic_pkg::CFG_PROD_TOL, 40'hffffffffff);
		run_directed();
		run_random(200);
		drain();
		write_reg(sic_pkg::CFG_POINT_TOL, 40'd300);
		write_reg(sic_pkg::CFG_PROD_TOL, 40'd1 << 34);
		run_random(300);
		drain();
		write_reg(sic_pkg::CFG_POINT_TOL, sic_pkg::TLW'(sic_pkg::POINT_TOL_RST));
		write_reg(sic_pkg::CFG_PROD_TOL, sic_pkg::PROD_TOL_RST);
		hold_off = 1;
		run_random(500);
		drain();
		stim_done = 1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 0;
				out_ready <= 0;
				repeat (300) @(posedge clk);
			end
			if ($urandom_range(99) < 25) begin
				out_ready <= 0;
				n = ($urandom_range(9) == 0) ? $urandom_range(80, 10) : $urandom_range(3, 1);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			if ($urandom_range(9) == 0) repeat ($urandom_range(50, 10)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stim_done) begin
			if (sb.errors == 0 && sb.pending.size() == 0)
				$display("segment_intersection_classifier regression: pass");
			else
				$display("segment_intersection_classifier regression: fail");
			$finish;
		end else if (cycles > 1500000) begin
			$display("segment_intersection_classifier regression: fail");
			$finish;
		end
	end
endmodule
